[rtl/eifalu_pkg.sv]
// shared types, constants and the float decode function of the exact integer float32 alu
package eifalu_pkg;

  // operation codes
  typedef enum logic [2:0] {
    OP_I2F = 3'd0,
    OP_F2I = 3'd1,
    OP_ADD = 3'd2,
    OP_SUB = 3'd3,
    OP_MUL = 3'd4
  } op_e;

  // field and range constants
  localparam logic [7:0]  ExpBias    = 8'd127;
  localparam logic [7:0]  ExpMaxInt  = 8'd157;   // bias plus 30
  localparam logic [7:0]  ExpAllOnes = 8'hFF;
  localparam logic [32:0] ExactMax   = 33'h0_00FF_FFFF;
  localparam logic signed [31:0] MulOpMax = 32'sh0000_FFFF;
  localparam logic signed [31:0] MulOpMin = -32'sh0000_FFFF;

  // decoded operand
  typedef struct packed {
    logic              ok;
    logic signed [31:0] val;
  } dec_t;

  // stage one to stage two
  typedef struct packed {
    logic [2:0]         op;
    logic               a_ok;
    logic               b_ok;
    logic signed [31:0] a_val;
    logic signed [31:0] b_val;
  } s1_t;

  // stage two to stage three
  typedef struct packed {
    logic               ok;
    logic               pass;   // result is the integer itself
    logic signed [32:0] val;
  } s2_t;

  // integer-valued normal single or signed zero to integer
  function automatic dec_t decode_float(input logic [31:0] bits);
    logic [7:0]  e;
    logic [22:0] f;
    logic [4:0]  sh;
    logic [30:0] x;
    logic [30:0] low_mask;
    logic [30:0] mag;
    dec_t        r;
    e        = bits[30:23];
    f        = bits[22:0];
    sh       = 5'(ExpMaxInt - e);
    x        = {1'b1, f, 7'b0};
    low_mask = ~({31{1'b1}} << sh);
    mag      = x >> sh;
    r.ok     = 1'b0;
    r.val    = '0;
    if (e == 8'd0 && f == 23'd0) begin
      r.ok = 1'b1;
    end else if (e != ExpAllOnes && e >= ExpBias && e <= ExpMaxInt &&
                 (x & low_mask) == 31'd0) begin
      r.ok  = 1'b1;
      r.val = bits[31] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end
    return r;
  endfunction

endpackage

[rtl/eifalu_decode.sv]
// first pipeline stage: operand decode
module eifalu_decode (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [2:0]        operation_i,
  input  logic [31:0]       operand_a_i,
  input  logic [31:0]       operand_b_i,
  output logic              valid_o,
  output eifalu_pkg::s1_t   stage_o
);

  logic            valid_q;
  eifalu_pkg::s1_t stage_d, stage_q;
  eifalu_pkg::dec_t dec_a, dec_b;

  // decode both operands; int to float takes operand a as an integer
  always_comb begin
    dec_a         = eifalu_pkg::decode_float(operand_a_i);
    dec_b         = eifalu_pkg::decode_float(operand_b_i);
    stage_d.op    = operation_i;
    stage_d.b_ok  = dec_b.ok;
    stage_d.b_val = dec_b.val;
    if (operation_i == eifalu_pkg::OP_I2F) begin
      stage_d.a_ok  = 1'b1;
      stage_d.a_val = $signed(operand_a_i);
    end else begin
      stage_d.a_ok  = dec_a.ok;
      stage_d.a_val = dec_a.val;
    end
  end

  // valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

[rtl/eifalu_arith.sv]
// second pipeline stage: exact add, subtract and multiply
module eifalu_arith (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  eifalu_pkg::s1_t stage_i,
  output logic            valid_o,
  output eifalu_pkg::s2_t stage_o
);

  logic               valid_q;
  eifalu_pkg::s2_t    stage_d, stage_q;
  logic signed [32:0] a_ext, b_ext;
  logic signed [33:0] prod;
  logic               mul_in_range;

  assign a_ext = 33'(stage_i.a_val);
  assign b_ext = 33'(stage_i.b_val);
  assign prod  = 34'($signed(stage_i.a_val[16:0])) * 34'($signed(stage_i.b_val[16:0]));
  assign mul_in_range = stage_i.a_val <= eifalu_pkg::MulOpMax &&
                        stage_i.a_val >= eifalu_pkg::MulOpMin &&
                        stage_i.b_val <= eifalu_pkg::MulOpMax &&
                        stage_i.b_val >= eifalu_pkg::MulOpMin;

  // operation select
  always_comb begin
    stage_d.ok   = 1'b0;
    stage_d.pass = 1'b0;
    stage_d.val  = a_ext;
    unique case (eifalu_pkg::op_e'(stage_i.op))
      eifalu_pkg::OP_I2F: begin
        stage_d.ok = stage_i.a_ok;
      end
      eifalu_pkg::OP_F2I: begin
        stage_d.ok   = stage_i.a_ok;
        stage_d.pass = 1'b1;
      end
      eifalu_pkg::OP_ADD: begin
        stage_d.ok  = stage_i.a_ok & stage_i.b_ok;
        stage_d.val = a_ext + b_ext;
      end
      eifalu_pkg::OP_SUB: begin
        stage_d.ok  = stage_i.a_ok & stage_i.b_ok;
        stage_d.val = a_ext - b_ext;
      end
      eifalu_pkg::OP_MUL: begin
        stage_d.ok  = stage_i.a_ok & stage_i.b_ok & mul_in_range;
        stage_d.val = 33'(prod);
      end
      default: begin
        stage_d.ok = 1'b0;
      end
    endcase
  end

  // valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

[rtl/eifalu_encode.sv]
// third pipeline stage: range check and single-precision encode
module eifalu_encode (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  eifalu_pkg::s2_t stage_i,
  output logic            valid_o,
  output logic [31:0]     result_o,
  output logic            status_o
);

  logic        valid_q;
  logic [31:0] result_d, result_q;
  logic        status_d, status_q;
  logic        neg;
  logic [32:0] mag;
  logic [4:0]  top;
  logic [22:0] frac;

  // magnitude and leading one
  always_comb begin
    neg  = stage_i.val[32];
    mag  = neg ? 33'(-stage_i.val) : 33'(stage_i.val);
    top  = 5'd0;
    for (int i = 0; i < 24; i++) begin
      if (mag[i]) begin
        top = 5'(i);
      end
    end
    frac = 23'({mag[22:0]} << (5'd23 - top));
  end

  // result select
  always_comb begin
    result_d = 32'd0;
    status_d = 1'b1;
    if (stage_i.ok) begin
      if (stage_i.pass) begin
        result_d = stage_i.val[31:0];
        status_d = 1'b0;
      end else if (mag <= eifalu_pkg::ExactMax) begin
        status_d = 1'b0;
        if (mag != 33'd0) begin
          result_d = {neg, 8'(top) + eifalu_pkg::ExpBias, frac};
        end
      end
    end
  end

  // valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      result_q <= result_d;
      status_q <= status_d;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;
  assign status_o = status_q;

endmodule

[rtl/exact_integer_float32_alu.sv]
// exact integer float32 alu: three-stage pipeline of decode, arithmetic and encode
// a request passes the decode, arithmetic and encode registers; its result
// shows with done_o for one cycle; throughput: one request every cycle
// the three pipeline registers set the latency; busy is never raised
// reset clears the stage valid bits, so requests in flight are dropped
// the receiver takes every result in its cycle and cannot hold the pipeline
module exact_integer_float32_alu (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  operation_i,
  input  logic [31:0] operand_a_i,
  input  logic [31:0] operand_b_i,
  output logic        done_o,
  output logic [31:0] result_o,
  output logic        status_o
);

  logic            accept;
  logic            v1, v2;
  eifalu_pkg::s1_t s1;
  eifalu_pkg::s2_t s2;

  // request accepted whenever start is high
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // decode stage
  eifalu_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (accept),
    .operation_i (operation_i),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .valid_o     (v1),
    .stage_o     (s1)
  );

  // arithmetic stage
  eifalu_arith u_arith (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v1),
    .stage_i (s1),
    .valid_o (v2),
    .stage_o (s2)
  );

  // encode stage
  eifalu_encode u_encode (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (v2),
    .stage_i  (s2),
    .valid_o  (done_o),
    .result_o (result_o),
    .status_o (status_o)
  );

  // an error result is always zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o |-> result_o == 32'd0)
    else $error("error result not zero");

  // every request comes out after passing the decode, arithmetic and encode registers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##3 done_o)
    else $error("result missing three cycles after request");

  // no result without a request taken through the decode, arithmetic and encode registers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, 3))
    else $error("result without request");

  // float results carry a zero or an exactly representable exponent
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !status_o && $past(operation_i, 3) != eifalu_pkg::OP_F2I |->
      result_o[30:23] == 8'd0 ||
      (result_o[30:23] >= 8'd127 && result_o[30:23] <= 8'd150))
    else $error("float result exponent out of exact range");

endmodule
